/* hdl/kctd_pkg.sv */
// Shared codes for the key combination trigger detector.
package kctd_pkg;

	localparam int KEY_W    = 12;
	localparam int CFG_W    = 16;
	localparam int HOLD_W   = 16;
	localparam int COUNT_W  = 3;
	localparam int MASK_W   = 4;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		OP_KEY   = 2'd0,
		OP_TICK  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ACT_DOWN  = 2'd0,
		ACT_UP    = 2'd1,
		ACT_OTHER = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		MODE_PRESSED  = 2'd0,
		MODE_REPEAT   = 2'd1,
		MODE_RELEASED = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FINAL_KEY     = 3'd0,
		REG_PRE_KEY_A     = 3'd1,
		REG_PRE_KEY_B     = 3'd2,
		REG_PRE_KEY_C     = 3'd3,
		REG_PRE_KEY_D     = 3'd4,
		REG_PRE_KEY_COUNT = 3'd5,
		REG_TRIGGER_MODE  = 3'd6,
		REG_HOLD_TICKS    = 3'd7
	} cfg_reg_t;

endpackage

/* hdl/key_combo_trigger_detector.sv */
// Top level of the key combination trigger detector.
// Watches key, tick and clear words for one configured hotkey and returns one
// result word (dispatch, consume) per input word. A word is held in the input
// register, is decided by a single pass of compare logic against the detector
// state, and lands in the result register; one word is accepted every cycle while
// results are taken. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while the block is idle; the block does not enforce it.
module key_combo_trigger_detector #(
	parameter int MAX_PRE_KEYS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [kctd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kctd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    opcode,
	input  logic [kctd_pkg::KEY_W-1:0]     key_code,
	input  logic [1:0]                    key_action,
	input  logic [kctd_pkg::MASK_W-1:0]    held_mask,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          dispatch,
	output logic                          consume
);
	import kctd_pkg::*;

	localparam int HW = MAX_PRE_KEYS + 1;

	// configuration
	logic [KEY_W-1:0]   final_key_q;
	logic [KEY_W-1:0]   pre_key_q [MAX_PRE_KEYS];
	logic [COUNT_W-1:0] pre_key_count_q;
	logic [1:0]         trigger_mode_q;
	logic [HOLD_W-1:0]  hold_ticks_q;

	// input register
	logic               valid_s1;
	logic [1:0]         opcode_s1;
	logic [KEY_W-1:0]   key_code_s1;
	logic [1:0]         key_action_s1;
	logic [MASK_W-1:0]  held_mask_s1;

	// detector state
	logic               first_down_sent_q, window_started_q, window_passed_q;
	logic               combo_active_q;
	logic [HOLD_W-1:0]  window_remaining_q;
	logic [HW-1:0]      held_combo_keys_q;

	logic               first_down_sent_d, window_started_d, window_passed_d;
	logic               combo_active_d;
	logic [HOLD_W-1:0]  window_remaining_d;
	logic [HW-1:0]      held_combo_keys_d;

	logic               advance;
	logic               disp_d, cons_d;
	logic [COUNT_W-1:0] used_cnt;
	logic [MAX_PRE_KEYS-1:0] slot_used;
	logic [HW-1:0]      code_bits;
	logic               is_final, is_pre, is_down, is_up, pre_match, qual;
	logic               dur_call, dur_ok;
	logic [HW-1:0]      held_up;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_key_q     <= '0;
			pre_key_count_q <= '0;
			trigger_mode_q  <= '0;
			hold_ticks_q    <= '0;
			for (int i = 0; i < MAX_PRE_KEYS; i++) pre_key_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FINAL_KEY:     final_key_q     <= cfg_data[KEY_W-1:0];
				REG_PRE_KEY_COUNT: pre_key_count_q <= cfg_data[COUNT_W-1:0];
				REG_TRIGGER_MODE:  trigger_mode_q  <= cfg_data[1:0];
				REG_HOLD_TICKS:    hold_ticks_q    <= cfg_data[HOLD_W-1:0];
				default: begin
					for (int i = 0; i < MAX_PRE_KEYS; i++) begin
						if (cfg_index == CFG_IDX_W'(int'(REG_PRE_KEY_A) + i))
							pre_key_q[i] <= cfg_data[KEY_W-1:0];
					end
				end
			endcase
		end
	end

	always_comb begin
		used_cnt = (pre_key_count_q > COUNT_W'(MAX_PRE_KEYS)) ?
			COUNT_W'(MAX_PRE_KEYS) : pre_key_count_q;
		code_bits    = '0;
		code_bits[0] = (key_code_s1 == final_key_q);
		pre_match    = 1'b1;
		for (int i = 0; i < MAX_PRE_KEYS; i++) begin
			slot_used[i]   = (COUNT_W'(i) < used_cnt);
			code_bits[i+1] = slot_used[i] && (pre_key_q[i] == key_code_s1);
			if (slot_used[i] && !held_mask_s1[i]) pre_match = 1'b0;
		end
		is_final = code_bits[0];
		is_pre   = |code_bits[HW-1:1];
		is_down  = (key_action_s1 == ACT_DOWN);
		is_up    = (key_action_s1 == ACT_UP);
		qual     = is_final && is_down && pre_match;
		held_up  = held_combo_keys_q & ~code_bits;

		dur_ok   = (hold_ticks_q == '0) || (window_started_q && window_passed_q);
		dur_call = 1'b0;

		first_down_sent_d  = first_down_sent_q;
		window_started_d   = window_started_q;
		window_passed_d    = window_passed_q;
		window_remaining_d = window_remaining_q;
		combo_active_d     = combo_active_q;
		held_combo_keys_d  = held_combo_keys_q;
		disp_d = 1'b0;
		cons_d = 1'b0;

		case (opcode_s1)
			OP_TICK: begin
				if (window_started_q && !window_passed_q && window_remaining_q != '0) begin
					window_remaining_d = window_remaining_q - HOLD_W'(1);
					if (window_remaining_q == HOLD_W'(1)) window_passed_d = 1'b1;
				end
			end
			OP_CLEAR: begin
				first_down_sent_d  = 1'b0;
				window_started_d   = 1'b0;
				window_passed_d    = 1'b0;
				window_remaining_d = '0;
				combo_active_d     = 1'b0;
				held_combo_keys_d  = '0;
			end
			OP_KEY: begin
				case (trigger_mode_q)
					MODE_PRESSED: begin
						cons_d   = is_final || (is_pre && is_up);
						dur_call = qual;
						if (qual && dur_ok && !first_down_sent_q) begin
							first_down_sent_d = 1'b1;
							disp_d = 1'b1;
						end
					end
					MODE_REPEAT: begin
						cons_d   = is_final || (is_pre && is_up);
						dur_call = qual;
						disp_d   = qual && dur_ok;
					end
					MODE_RELEASED: begin
						cons_d = combo_active_q && (is_final || is_pre);
						if (combo_active_q) begin
							if (is_final || is_pre) begin
								if (is_down) begin
									held_combo_keys_d = held_combo_keys_q | code_bits;
								end else if (is_up) begin
									held_combo_keys_d = held_up;
									if (held_up == '0) combo_active_d = 1'b0;
								end
								disp_d = 1'b1;
							end
						end else begin
							dur_call = qual;
							if (qual && dur_ok) begin
								combo_active_d    = 1'b1;
								held_combo_keys_d = {slot_used, 1'b1};
								disp_d = 1'b1;
							end
						end
					end
					default: ;
				endcase
				// first qualifying down opens the hold window
				if (dur_call && hold_ticks_q != '0 && !window_started_q) begin
					window_started_d   = 1'b1;
					window_remaining_d = hold_ticks_q;
					window_passed_d    = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1           <= 1'b0;
			out_valid          <= 1'b0;
			first_down_sent_q  <= 1'b0;
			window_started_q   <= 1'b0;
			window_passed_q    <= 1'b0;
			window_remaining_q <= '0;
			combo_active_q     <= 1'b0;
			held_combo_keys_q  <= '0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance) begin
				out_valid          <= 1'b1;
				first_down_sent_q  <= first_down_sent_d;
				window_started_q   <= window_started_d;
				window_passed_q    <= window_passed_d;
				window_remaining_q <= window_remaining_d;
				combo_active_q     <= combo_active_d;
				held_combo_keys_q  <= held_combo_keys_d;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1     <= opcode;
			key_code_s1   <= key_code;
			key_action_s1 <= key_action;
			held_mask_s1  <= held_mask;
		end
		if (advance) begin
			dispatch <= disp_d;
			consume  <= cons_d;
		end
	end

endmodule

/* hdl/kctd_checker.sv */
// Port-level checker for the key combination trigger detector, with its bind.
module kctd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic dispatch,
	input logic consume
);
	import kctd_pkg::*;

	// input stalls only behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a blocked result");

	// a new result needs a word taken in earlier
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready))
		else $error("result appeared while input was stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped before accept");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(dispatch) && $stable(consume)))
		else $error("result changed while stalled");

endmodule

bind key_combo_trigger_detector kctd_checker u_kctd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.dispatch  (dispatch),
	.consume   (consume)
);

/* bench/tb.sv */
// Self-checking bench for the key combination trigger detector.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kctd_pkg::*;

	localparam logic [1:0] OP_UNKNOWN   = 2'd3;
	localparam logic [1:0] ACT_RESERVED = 2'd3;
	localparam logic [1:0] MODE_UNKNOWN = 2'd3;
	localparam int         MAX_SLOTS    = 4;
	localparam int         PIPE_LAT     = 4;

	typedef struct packed {
		logic disp;
		logic cons;
	} flags_t;

	class trigger_tracker;
		logic [KEY_W-1:0]   final_key;
		logic [KEY_W-1:0]   pre_key [MAX_SLOTS];
		logic [COUNT_W-1:0] slot_count;
		logic [1:0]         mode;
		logic [HOLD_W-1:0]  hold_ticks;

		logic               first_sent, win_started, win_passed, active;
		logic [HOLD_W-1:0]  win_left;
		logic [4:0]         held_keys;

		flags_t             expected_flags [$];
		int                 mismatches;

		function new();
			final_key = '0;
			foreach (pre_key[i]) pre_key[i] = '0;
			slot_count = '0;
			mode = MODE_PRESSED;
			hold_ticks = '0;
			clear_state();
			mismatches = 0;
		endfunction

		function void clear_state();
			first_sent = 1'b0;
			win_started = 1'b0;
			win_passed = 1'b0;
			active = 1'b0;
			win_left = '0;
			held_keys = '0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
			case (idx)
			REG_FINAL_KEY:     final_key = v[KEY_W-1:0];
			REG_PRE_KEY_A:     pre_key[0] = v[KEY_W-1:0];
			REG_PRE_KEY_B:     pre_key[1] = v[KEY_W-1:0];
			REG_PRE_KEY_C:     pre_key[2] = v[KEY_W-1:0];
			REG_PRE_KEY_D:     pre_key[3] = v[KEY_W-1:0];
			REG_PRE_KEY_COUNT: slot_count = v[COUNT_W-1:0];
			REG_TRIGGER_MODE:  mode = v[1:0];
			REG_HOLD_TICKS:    hold_ticks = v[HOLD_W-1:0];
			default: ;
			endcase
		endfunction

		function int slots_used();
			return (slot_count > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
		endfunction

		function logic [MASK_W-1:0] need_mask();
			logic [4:0] m;
			m = (5'd1 << slots_used()) - 5'd1;
			return m[MASK_W-1:0];
		endfunction

		// bit 0 final key, bit 1+i pre-key slot i
		function logic [4:0] key_bits(logic [KEY_W-1:0] code);
			logic [4:0] bits;
			bits = '0;
			bits[0] = (code == final_key);
			for (int i = 0; i < MAX_SLOTS; i++)
				if (i < slots_used() && pre_key[i] == code)
					bits[i+1] = 1'b1;
			return bits;
		endfunction

		function logic window_ok();
			if (hold_ticks == 0)
				return 1'b1;
			if (!win_started) begin
				win_started = 1'b1;
				win_left = hold_ticks;
				win_passed = 1'b0;
				return 1'b0;
			end
			return win_passed;
		endfunction

		function flags_t decide(logic [1:0] op, logic [KEY_W-1:0] code, logic [1:0] act,
				logic [MASK_W-1:0] mask);
			flags_t     f;
			logic [4:0] bits;
			logic       is_final, is_pre, down, qualify, ok;
			f = '0;
			case (op)
			OP_TICK: begin
				if (win_started && !win_passed && win_left != 0) begin
					win_left--;
					if (win_left == 0)
						win_passed = 1'b1;
				end
			end
			OP_CLEAR: clear_state();
			OP_KEY: begin
				bits = key_bits(code);
				is_final = bits[0];
				is_pre = |bits[4:1];
				down = (act == ACT_DOWN);
				qualify = is_final && down && ((mask & need_mask()) == need_mask());
				// consume looks at the state before this word
				if (mode == MODE_PRESSED || mode == MODE_REPEAT)
					f.cons = is_final || (is_pre && act == ACT_UP);
				else if (mode == MODE_RELEASED)
					f.cons = active && (is_final || is_pre);
				case (mode)
				MODE_PRESSED: begin
					if (qualify) begin
						ok = window_ok();
						if (ok && !first_sent) begin
							first_sent = 1'b1;
							f.disp = 1'b1;
						end
					end
				end
				MODE_REPEAT: begin
					if (qualify)
						f.disp = window_ok();
				end
				MODE_RELEASED: begin
					if (active) begin
						if (is_final || is_pre) begin
							if (down) begin
								held_keys |= bits;
							end else if (act == ACT_UP) begin
								held_keys &= ~bits;
								if (held_keys == 0)
									active = 1'b0;
							end
							f.disp = 1'b1;
						end
					end else if (qualify) begin
						if (window_ok()) begin
							active = 1'b1;
							held_keys = {need_mask(), 1'b1};
							f.disp = 1'b1;
						end
					end
				end
				default: ;
				endcase
			end
			default: ;
			endcase
			return f;
		endfunction

		function void take_word(logic [1:0] op, logic [KEY_W-1:0] code, logic [1:0] act,
				logic [MASK_W-1:0] mask);
			expected_flags.push_back(decide(op, code, act, mask));
		endfunction

		function int pending();
			return expected_flags.size();
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(logic d, logic c);
			flags_t want;
			if (expected_flags.size() == 0) begin
				report($sformatf("result dispatch=%0b consume=%0b with none pending", d, c));
				return;
			end
			want = expected_flags.pop_front();
			if (d !== want.disp)
				report($sformatf("dispatch %0b, expected %0b", d, want.disp));
			if (c !== want.cons)
				report($sformatf("consume %0b, expected %0b", c, want.cons));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           opcode;
	logic [KEY_W-1:0]     key_code;
	logic [1:0]           key_action;
	logic [MASK_W-1:0]    held_mask;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 dispatch;
	logic                 consume;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	trigger_tracker tracker;

	key_combo_trigger_detector uut (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.in_valid,
		.in_ready,
		.opcode,
		.key_code,
		.key_action,
		.held_mask,
		.out_valid,
		.out_ready,
		.dispatch,
		.consume
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			tracker.check_result(dispatch, consume);

	initial begin
		#(2_000_000);
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_word(logic [1:0] op, logic [KEY_W-1:0] code, logic [1:0] act,
			logic [MASK_W-1:0] mask);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		key_code   <= code;
		key_action <= act;
		held_mask  <= mask;
		do begin
			@(posedge clk);
		end while (!in_ready);
		tracker.take_word(op, code, act, mask);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (PIPE_LAT) @(negedge clk);
	endtask

	// leaves cfg_we high; set_config lowers it after the last register
	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		tracker.set_reg(idx, v);
	endtask

	task automatic set_config(logic [KEY_W-1:0] fk, logic [KEY_W-1:0] a, logic [KEY_W-1:0] b,
			logic [KEY_W-1:0] c, logic [KEY_W-1:0] d, logic [COUNT_W-1:0] cnt,
			logic [1:0] mode, logic [HOLD_W-1:0] hold);
		write_reg(REG_FINAL_KEY, CFG_W'(fk));
		write_reg(REG_PRE_KEY_A, CFG_W'(a));
		write_reg(REG_PRE_KEY_B, CFG_W'(b));
		write_reg(REG_PRE_KEY_C, CFG_W'(c));
		write_reg(REG_PRE_KEY_D, CFG_W'(d));
		write_reg(REG_PRE_KEY_COUNT, CFG_W'(cnt));
		write_reg(REG_TRIGGER_MODE, CFG_W'(mode));
		write_reg(REG_HOLD_TICKS, CFG_W'(hold));
		cfg_we <= 1'b0;
	endtask

	function automatic logic [KEY_W-1:0] any_code();
		logic [31:0] r;
		r = $urandom;
		case (r[31:29])
		3'd0: return '0;
		3'd1: return '1;
		default: return r[KEY_W-1:0];
		endcase
	endfunction

	task automatic random_config();
		logic [KEY_W-1:0]   fk;
		logic [KEY_W-1:0]   pk [MAX_SLOTS];
		logic [COUNT_W-1:0] cnt;
		logic [1:0]         mode;
		logic [HOLD_W-1:0]  hold;
		logic [31:0]        r;
		int                 pick;
		fk = any_code();
		// equal codes now and then
		foreach (pk[i])
			pk[i] = ($urandom_range(4) == 0) ? fk : any_code();
		cnt = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
		mode = ($urandom_range(19) == 0) ? MODE_UNKNOWN : 2'($urandom_range(2));
		r = $urandom;
		pick = $urandom_range(9);
		if (pick < 4)
			hold = '0;
		else if (pick < 8)
			hold = 16'($urandom_range(4, 1));
		else if (pick == 8)
			hold = 16'($urandom_range(20, 5));
		else
			hold = r[0] ? '1 : r[HOLD_W:1];
		set_config(fk, pk[0], pk[1], pk[2], pk[3], cnt, mode, hold);
	endtask

	task automatic send_random();
		logic [31:0]       r;
		logic [1:0]        op, act;
		logic [KEY_W-1:0]  code;
		logic [MASK_W-1:0] mask;
		int                pick;
		r = $urandom;
		code = r[KEY_W-1:0];
		act = r[13:12];
		mask = r[17:14];
		op = OP_KEY;
		pick = $urandom_range(99);
		if (pick < 25) begin
			op = OP_TICK;
		end else if (pick < 29) begin
			op = OP_CLEAR;
		end else if (pick < 31) begin
			op = OP_UNKNOWN;
		end else begin
			pick = $urandom_range(9);
			if (pick < 4)
				code = tracker.final_key;
			else if (pick < 8)
				code = tracker.pre_key[r[19:18]];
			pick = $urandom_range(19);
			if (pick < 9)
				act = ACT_DOWN;
			else if (pick < 17)
				act = ACT_UP;
			if ($urandom_range(3) != 0)
				mask = mask | tracker.need_mask();
		end
		send_word(op, code, act, mask);
	endtask

	initial begin
		tracker = new();
		cfg_we = 1'b0;
		cfg_index = REG_FINAL_KEY;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_KEY;
		key_code = '0;
		key_action = ACT_DOWN;
		held_mask = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// pressed once: repeat suppression, pre-key release, clear
		set_config(12'hFFF, 12'h000, 12'hABC, 12'h555, 12'hAAA, 3'd2, MODE_PRESSED, 16'd0);
		send_word(OP_KEY, 12'hFFF, ACT_DOWN, 4'b0011);
		send_word(OP_KEY, 12'hFFF, ACT_DOWN, 4'b1111);
		send_word(OP_KEY, 12'h000, ACT_UP, 4'b0000);
		send_word(OP_KEY, 12'hFFF, ACT_DOWN, 4'b0001);
		send_word(OP_UNKNOWN, 12'hFFF, ACT_DOWN, 4'b1111);
		send_word(OP_CLEAR, 12'h000, ACT_UP, 4'b0000);
		send_word(OP_KEY, 12'hFFF, ACT_DOWN, 4'b0011);
		drain();

		// repeat with a two-tick hold window
		set_config(12'hFFF, 12'h000, 12'hABC, 12'h555, 12'hAAA, 3'd0, MODE_REPEAT, 16'd2);
		send_word(OP_KEY, 12'hFFF, ACT_DOWN, 4'b0000);
		send_word(OP_TICK, 12'h000, ACT_DOWN, 4'b0000);
		send_word(OP_KEY, 12'hFFF, ACT_DOWN, 4'b0000);
		send_word(OP_TICK, 12'h000, ACT_DOWN, 4'b0000);
		send_word(OP_KEY, 12'hFFF, ACT_DOWN, 4'b0000);
		send_word(OP_KEY, 12'hFFF, ACT_OTHER, 4'b0000);
		send_word(OP_KEY, 12'hFFF, ACT_RESERVED, 4'b1111);
		drain();

		// all released, slot A shares the final key code
		set_config(12'hFFF, 12'hFFF, 12'h000, 12'h555, 12'hAAA, 3'd4, MODE_RELEASED, 16'd0);
		send_word(OP_KEY, 12'hFFF, ACT_DOWN, 4'b1111);
		send_word(OP_KEY, 12'h000, ACT_OTHER, 4'b0000);
		send_word(OP_KEY, 12'h000, ACT_UP, 4'b0000);
		send_word(OP_KEY, 12'h555, ACT_UP, 4'b0000);
		send_word(OP_KEY, 12'hAAA, ACT_UP, 4'b0000);
		send_word(OP_KEY, 12'hFFF, ACT_UP, 4'b0000);
		send_word(OP_KEY, 12'hFFF, ACT_UP, 4'b0000);
		drain();

		// unknown mode, oversized slot count, longest hold
		set_config(12'h000, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 3'd7, MODE_UNKNOWN, 16'hFFFF);
		send_word(OP_KEY, 12'h000, ACT_DOWN, 4'b1111);
		send_word(OP_KEY, 12'hFFF, ACT_UP, 4'b1111);
		drain();
		set_config(12'h000, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 3'd7, MODE_PRESSED, 16'hFFFF);
		send_word(OP_KEY, 12'h000, ACT_DOWN, 4'b1111);
		send_word(OP_TICK, 12'hFFF, ACT_OTHER, 4'b1111);

		for (int phase = 0; phase < 12; phase++) begin
			drain();
			case (phase)
			0: set_config('0, '1, '1, '1, '1, 3'd4, MODE_RELEASED, '1);
			1: set_config('1, '0, '0, '0, '0, 3'd0, MODE_REPEAT, '0);
			default: random_config();
			endcase
			send_idle_pct = (phase % 4 == 1) ? 83 : (phase % 4 == 3) ? 19 : 0;
			recv_stall_pct = (phase % 4 == 2) ? 83 : (phase % 4 == 3) ? 19 : 0;
			if (phase == 4)
				hold_request = 80;
			repeat (50) send_random();
		end
		drain();

		if (tracker.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
